// ===== rtl/itt_pkg.sv =====
// ----------------------------------------------------------------------------
// itt_pkg
// Shared types and codes of the interval timer table: command and result
// beats, operation codes and status codes.
// ----------------------------------------------------------------------------
package itt_pkg;

  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_POLL   = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [47:0]        time_ns;
    logic signed [15:0] repeat_count;
    logic [23:0]        timer_id;
  } cmd_t;

  typedef struct packed {
    logic [23:0] assigned_id;
    logic        fired;
    status_t     status;
  } res_t;

endpackage

// ===== rtl/itt_slot_ram.sv =====
// ----------------------------------------------------------------------------
// itt_slot_ram
// Slot record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module itt_slot_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 138
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/itt_slot_update.sv =====
// ----------------------------------------------------------------------------
// itt_slot_update
// Tick datapath for one slot a cycle: saturating add of the delta, then
// period compare, firing, repeat count-down and freeing of expired slots in the next stage.
// ----------------------------------------------------------------------------
module itt_slot_update #(
  parameter int SLOTS     = 128,
  parameter int ID_BITS   = 24,
  parameter int TIME_BITS = 48
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     vld,
  input  logic [$clog2(SLOTS)-1:0] idx,
  input  logic [ID_BITS-1:0]       id,
  input  logic [TIME_BITS-1:0]     period,
  input  logic [TIME_BITS-1:0]     accum,
  input  logic signed [16:0]       rep,
  input  logic                     done,
  input  logic [TIME_BITS-1:0]     delta,
  output logic                     out_vld,
  output logic                     wr_en,
  output logic [$clog2(SLOTS)-1:0] wr_idx,
  output logic [ID_BITS-1:0]       wr_id,
  output logic [TIME_BITS-1:0]     wr_period,
  output logic [TIME_BITS-1:0]     wr_accum,
  output logic signed [16:0]       wr_rep,
  output logic                     wr_done
);

  localparam int AW = $clog2(SLOTS);

  logic [TIME_BITS:0]     sum_w;
  logic [AW-1:0]          s1_idx;
  logic [ID_BITS-1:0]     s1_id;
  logic [TIME_BITS-1:0]   s1_period;
  logic [TIME_BITS-1:0]   s1_sum;
  logic signed [16:0]     s1_rep;
  logic                   s1_done;
  logic                   fire;

  assign sum_w = {1'b0, accum} + {1'b0, delta};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx    <= idx;
    s1_id     <= id;
    s1_period <= period;
    // saturate on carry out
    s1_sum    <= sum_w[TIME_BITS] ? '1 : sum_w[TIME_BITS-1:0];
    s1_rep    <= rep;
    s1_done   <= done;
  end

  assign fire   = (s1_sum >= s1_period);
  assign wr_en  = out_vld && (s1_id != '0);
  assign wr_idx = s1_idx;

  always_comb begin
    if (s1_rep == 17'sd0) begin
      // expired slot is freed without firing
      wr_id     = '0;
      wr_period = '0;
      wr_accum  = '0;
      wr_rep    = '0;
      wr_done   = 1'b0;
    end else begin
      wr_id     = s1_id;
      wr_period = s1_period;
      wr_accum  = fire ? (s1_sum - s1_period) : s1_sum;
      wr_done   = fire | s1_done;
      wr_rep    = (fire && !s1_rep[16]) ? (s1_rep - 17'sd1) : s1_rep;
    end
  end

endmodule

// ===== rtl/interval_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// interval_timer_table_core
// Table of interval timers held in one slot memory, walked by a sequencer.
// ----------------------------------------------------------------------------
// Commands arrive on cmd (valid/ready) and each gives exactly one result beat
// on res (valid/ready). Create takes the next id and stores the timer in the
// lowest free slot, poll reports and clears a timer's done flag, delete frees
// the lowest slot holding the id, and tick adds the delta to every used slot.
// All slot state sits in one memory with a registered read; the sequencer
// streams one slot read per cycle through it.
// A create, poll or delete walks from slot 0 and stops at the first hit or
// at the last slot; a tick always walks every slot, through the single read
// port and the two stage update path behind it.
// cmd_ready rises in the same cycle as res_valid.
// One command is in work at a time; the next one is taken once the current
// result sits in the output register, so a stalled receiver holds off the
// command after that one.
// After reset the memory is cleared one slot per cycle, every slot in turn, with
// cmd_ready low; next_id restarts at 1.
// ----------------------------------------------------------------------------
module interval_timer_table_core #(
  parameter int SLOTS     = 128,
  parameter int ID_BITS   = 24,
  parameter int TIME_BITS = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  itt_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output itt_pkg::res_t res
);

  localparam int AW = $clog2(SLOTS);
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] period;
    logic [TIME_BITS-1:0] accum;
    logic signed [16:0]   rep;
    logic                 done;
  } slot_t;

  localparam int REC_W = $bits(slot_t);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state;

  // latched command
  itt_pkg::mode_t       mode_q;
  logic [TIME_BITS-1:0] time_q;
  logic signed [16:0]   rep_q;
  logic [ID_BITS-1:0]   key_q;
  logic [ID_BITS-1:0]   cur_id;
  logic [ID_BITS-1:0]   next_id;
  logic [ID_BITS-1:0]   next_id_inc;

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_busy;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;

  logic                 pend_fired;
  itt_pkg::status_t     pend_status;
  logic                 pend_fired_next;
  itt_pkg::status_t     pend_status_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  slot_t         ram_wrec;
  logic          ram_re;
  logic [REC_W-1:0] ram_rdata;
  slot_t         rd_rec;

  logic          is_tick;
  logic          hit;
  logic          scan_end;
  logic          tick_end;
  logic          finish;
  logic          load;
  logic          accept;

  logic                 upd_vld;
  logic                 upd_we;
  logic [AW-1:0]        upd_idx;
  slot_t                upd_rec;

  assign rd_rec    = slot_t'(ram_rdata);
  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign is_tick   = (mode_q == itt_pkg::MODE_TICK);
  assign ram_re    = (state == S_SCAN) && rd_busy;
  assign load      = (state == S_RESP) && (!res_valid || res_ready);

  assign next_id_inc = (next_id + 1'b1 == '0) ? ID_BITS'(1) : next_id + 1'b1;

  always_comb begin
    unique case (mode_q)
      itt_pkg::MODE_CREATE: hit = (rd_rec.id == '0);
      itt_pkg::MODE_POLL,
      itt_pkg::MODE_DELETE: hit = (key_q != '0) && (rd_rec.id == key_q);
      itt_pkg::MODE_TICK:   hit = 1'b0;
      default:              hit = 1'b0;
    endcase
  end

  assign scan_end = (state == S_SCAN) && !is_tick && rd_vld && (hit || rd_idx == LAST);
  assign tick_end = (state == S_SCAN) && is_tick && upd_vld && (upd_idx == LAST);
  assign finish   = scan_end || tick_end;

  itt_slot_update #(
    .SLOTS     (SLOTS),
    .ID_BITS   (ID_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .vld       (rd_vld && is_tick && (state == S_SCAN)),
    .idx       (rd_idx),
    .id        (rd_rec.id),
    .period    (rd_rec.period),
    .accum     (rd_rec.accum),
    .rep       (rd_rec.rep),
    .done      (rd_rec.done),
    .delta     (time_q),
    .out_vld   (upd_vld),
    .wr_en     (upd_we),
    .wr_idx    (upd_idx),
    .wr_id     (upd_rec.id),
    .wr_period (upd_rec.period),
    .wr_accum  (upd_rec.accum),
    .wr_rep    (upd_rec.rep),
    .wr_done   (upd_rec.done)
  );

  // write port: clearing pass, table hit, or tick write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx;
    ram_wrec  = '0;
    priority if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (scan_end && hit) begin
      ram_we    = 1'b1;
      ram_waddr = rd_idx;
      unique case (mode_q)
        itt_pkg::MODE_CREATE: begin
          ram_wrec.id     = cur_id;
          ram_wrec.period = time_q;
          ram_wrec.rep    = rep_q;
        end
        itt_pkg::MODE_POLL: begin
          ram_wrec      = rd_rec;
          ram_wrec.done = 1'b0;
        end
        itt_pkg::MODE_DELETE: ram_wrec = '0;
        itt_pkg::MODE_TICK:   ram_wrec = '0;
        default:              ram_wrec = '0;
      endcase
    end else if (is_tick && (state == S_SCAN)) begin
      ram_we    = upd_we;
      ram_waddr = upd_idx;
      ram_wrec  = upd_rec;
    end else begin
      ram_we = 1'b0;
    end
  end

  itt_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH (REC_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (REC_W'(ram_wrec)),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      rd_busy  <= 1'b0;
      rd_vld   <= 1'b0;
      next_id  <= ID_BITS'(1);
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state   <= S_SCAN;
            rd_busy <= 1'b1;
            rd_vld  <= 1'b0;
            if (cmd.mode == itt_pkg::MODE_CREATE) begin
              next_id <= next_id_inc;
            end
          end
        end
        S_SCAN: begin
          if (finish) begin
            state   <= S_RESP;
            rd_busy <= 1'b0;
            rd_vld  <= 1'b0;
          end else begin
            rd_vld <= rd_busy;
            if (rd_busy && rd_addr == LAST) begin
              rd_busy <= 1'b0;
            end
          end
        end
        S_RESP: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= cmd.mode;
      time_q  <= TIME_BITS'(cmd.time_ns);
      rep_q   <= {cmd.repeat_count[15], cmd.repeat_count};
      key_q   <= ID_BITS'(cmd.timer_id);
      cur_id  <= next_id;
      rd_addr <= '0;
    end else if (ram_re) begin
      rd_addr <= rd_addr + 1'b1;
    end
    if (ram_re) begin
      rd_idx <= rd_addr;
    end
  end

  // result of the finished walk
  always_comb begin
    pend_fired_next  = 1'b0;
    pend_status_next = itt_pkg::STATUS_OK;
    unique case (mode_q)
      itt_pkg::MODE_CREATE: begin
        if (!hit) begin
          pend_status_next = itt_pkg::STATUS_FULL;
        end
      end
      itt_pkg::MODE_POLL: begin
        if (hit) begin
          pend_fired_next = rd_rec.done;
        end else begin
          pend_status_next = itt_pkg::STATUS_NOT_FOUND;
        end
      end
      itt_pkg::MODE_DELETE: begin
        if (!hit) begin
          pend_status_next = itt_pkg::STATUS_NOT_FOUND;
        end
      end
      itt_pkg::MODE_TICK:   pend_status_next = itt_pkg::STATUS_OK;
      default:              pend_status_next = itt_pkg::STATUS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      pend_fired  <= pend_fired_next;
      pend_status <= pend_status_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.assigned_id <= (mode_q == itt_pkg::MODE_CREATE) ? 24'(cur_id) : 24'(key_q);
      res.fired       <= pend_fired;
      res.status      <= pend_status;
    end
  end

endmodule

// ===== tb/sv/tb_interval_timer_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_timer_table_core
// Self-checking bench for the interval timer table core.
// ----------------------------------------------------------------------------
// Commands go in one beat at a time on cmd, and every accepted command is run
// through a local copy of the timer table to get the result beat it must give.
// A checker process takes each res beat in order and compares it field by
// field. Directed commands hit id zero, unknown ids, saturating ticks, zero
// periods and repeat counts that run out. The table is then filled past
// capacity, and a long mix of creates, polls, deletes and ticks follows. Both
// sides idle at random, with runs of back-to-back beats in between.
// ----------------------------------------------------------------------------
module tb_interval_timer_table_core;

  localparam int SLOTS = 128;
  localparam logic [47:0] TIME_MAX = '1;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  itt_pkg::cmd_t cmd;
  logic res_valid;
  logic res_ready;
  itt_pkg::res_t res;

  interval_timer_table_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // local copy of the timer table
  logic        [23:0] tbl_id     [SLOTS];
  logic        [47:0] tbl_period [SLOTS];
  logic        [47:0] tbl_accum  [SLOTS];
  logic signed [16:0] tbl_repeat [SLOTS];
  logic               tbl_done   [SLOTS];
  logic        [23:0] id_next;

  itt_pkg::res_t pending_results[$];

  int n_errors;
  int n_cmds;
  int n_ticks;
  int n_fired;
  int n_full;
  int n_not_found;
  bit src_idle_en;
  bit sink_idle_en;

  function automatic void clear_slot(int s);
    tbl_id[s]     = '0;
    tbl_period[s] = '0;
    tbl_accum[s]  = '0;
    tbl_repeat[s] = '0;
    tbl_done[s]   = 1'b0;
  endfunction

  function automatic int first_slot_with(logic [23:0] id);
    for (int s = 0; s < SLOTS; s++) begin
      if (tbl_id[s] == id) return s;
    end
    return -1;
  endfunction

  function automatic itt_pkg::res_t predict_timer_result(itt_pkg::cmd_t c);
    itt_pkg::res_t r;
    int            hit;
    logic [48:0]   sum;
    r.assigned_id = c.timer_id;
    r.fired       = 1'b0;
    r.status      = itt_pkg::STATUS_OK;
    case (c.mode)
      itt_pkg::MODE_CREATE: begin
        r.assigned_id = id_next;
        id_next = id_next + 24'd1;
        if (id_next == '0) id_next = 24'd1;
        hit = first_slot_with('0);
        if (hit < 0) begin
          r.status = itt_pkg::STATUS_FULL;
        end else begin
          tbl_id[hit]     = r.assigned_id;
          tbl_period[hit] = c.time_ns;
          tbl_accum[hit]  = '0;
          tbl_repeat[hit] = {c.repeat_count[15], c.repeat_count};
          tbl_done[hit]   = 1'b0;
        end
      end
      itt_pkg::MODE_POLL: begin
        hit = (c.timer_id == '0) ? -1 : first_slot_with(c.timer_id);
        if (hit < 0) begin
          r.status = itt_pkg::STATUS_NOT_FOUND;
        end else begin
          r.fired = tbl_done[hit];
          tbl_done[hit] = 1'b0;
        end
      end
      itt_pkg::MODE_DELETE: begin
        hit = (c.timer_id == '0) ? -1 : first_slot_with(c.timer_id);
        if (hit < 0) r.status = itt_pkg::STATUS_NOT_FOUND;
        else clear_slot(hit);
      end
      itt_pkg::MODE_TICK: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (tbl_id[s] != '0) begin
            if (tbl_repeat[s] == 0) begin
              clear_slot(s);
            end else begin
              sum = {1'b0, tbl_accum[s]} + {1'b0, c.time_ns};
              if (sum[48]) sum = {1'b0, TIME_MAX};
              if (sum[47:0] >= tbl_period[s]) begin
                sum = sum - {1'b0, tbl_period[s]};
                tbl_done[s] = 1'b1;
                if (tbl_repeat[s] > 0) tbl_repeat[s] = tbl_repeat[s] - 17'sd1;
              end
              tbl_accum[s] = sum[47:0];
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic itt_pkg::cmd_t make_cmd(itt_pkg::mode_t m, logic [47:0] t,
                                             logic signed [15:0] rc, logic [23:0] id);
    itt_pkg::cmd_t c;
    c.mode         = m;
    c.time_ns      = t;
    c.repeat_count = rc;
    c.timer_id     = id;
    return c;
  endfunction

  function automatic logic [47:0] rand_wide();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic logic [47:0] rand_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return rand_wide();
      default: return 48'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic signed [15:0] rand_repeat();
    case ($urandom_range(0, 9))
      0:       return 16'sd0;
      1, 2, 3: return 16'($urandom_range(1, 4));
      4:       return 16'($urandom_range(5, 40));
      5:       return 16'($urandom);
      6:       return 16'sh8000;
      default: return -16'sd1;
    endcase
  endfunction

  function automatic logic [47:0] rand_delta();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return rand_wide();
      2:       return TIME_MAX;
      default: return 48'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [23:0] live_id();
    logic [23:0] ids[$];
    for (int s = 0; s < SLOTS; s++) begin
      if (tbl_id[s] != '0) ids.push_back(tbl_id[s]);
    end
    if (ids.size() == 0) return 24'($urandom);
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  // entered and left on a falling edge; valid stays up between beats with no gap
  task automatic send_cmd(itt_pkg::cmd_t c);
    int gap;
    if ($urandom_range(0, 31) == 0) src_idle_en = !src_idle_en;
    gap = src_idle_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!cmd_ready);
    pending_results.push_back(predict_timer_result(c));
    n_cmds++;
    if (c.mode == itt_pkg::MODE_TICK) n_ticks++;
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_cmd(make_cmd(itt_pkg::MODE_POLL, '0, '0, '0));
    send_cmd(make_cmd(itt_pkg::MODE_DELETE, TIME_MAX, -16'sd1, '0));
    send_cmd(make_cmd(itt_pkg::MODE_POLL, '0, '0, 24'hFFFFFF));
    send_cmd(make_cmd(itt_pkg::MODE_CREATE, '0, -16'sd1, '0));      // id 1, fires every tick
    send_cmd(make_cmd(itt_pkg::MODE_CREATE, TIME_MAX, 16'sd32767, 24'hFFFFFF)); // id 2
    send_cmd(make_cmd(itt_pkg::MODE_CREATE, 48'd10, 16'sd0, '0));   // id 3, freed on tick
    send_cmd(make_cmd(itt_pkg::MODE_CREATE, 48'd5, 16'sd2, '0));    // id 4
    send_cmd(make_cmd(itt_pkg::MODE_CREATE, 48'd7, 16'sh8000, '0)); // id 5, forever
    send_cmd(make_cmd(itt_pkg::MODE_POLL, '0, '0, 24'd1));
    send_cmd(make_cmd(itt_pkg::MODE_TICK, '0, '0, 24'd77));
    send_cmd(make_cmd(itt_pkg::MODE_POLL, '0, '0, 24'd1));
    send_cmd(make_cmd(itt_pkg::MODE_POLL, '0, '0, 24'd1));
    send_cmd(make_cmd(itt_pkg::MODE_POLL, '0, '0, 24'd3));
    // saturating sums, repeat of id 4 runs out
    send_cmd(make_cmd(itt_pkg::MODE_TICK, TIME_MAX, '0, '0));
    send_cmd(make_cmd(itt_pkg::MODE_TICK, TIME_MAX, '0, '0));
    send_cmd(make_cmd(itt_pkg::MODE_TICK, 48'd1, '0, '0));
    send_cmd(make_cmd(itt_pkg::MODE_POLL, '0, '0, 24'd2));
    send_cmd(make_cmd(itt_pkg::MODE_POLL, '0, '0, 24'd4));
    send_cmd(make_cmd(itt_pkg::MODE_POLL, '0, '0, 24'd5));
    send_cmd(make_cmd(itt_pkg::MODE_DELETE, '0, '0, 24'd5));
    send_cmd(make_cmd(itt_pkg::MODE_DELETE, '0, '0, 24'd5));
    send_cmd(make_cmd(itt_pkg::MODE_DELETE, '0, '0, 24'd1));
    // reused slot must come up with done and accum cleared
    send_cmd(make_cmd(itt_pkg::MODE_CREATE, 48'd3, 16'sd1, '0));
    send_cmd(make_cmd(itt_pkg::MODE_POLL, '0, '0, 24'd6));
  endtask

  task automatic test_table_full();
    while (first_slot_with('0) >= 0) begin
      send_cmd(make_cmd(itt_pkg::MODE_CREATE, rand_period(), rand_repeat(), 24'($urandom)));
    end
    repeat (4) begin
      send_cmd(make_cmd(itt_pkg::MODE_CREATE, rand_wide(), 16'($urandom), 24'($urandom)));
    end
    repeat (8) send_cmd(make_cmd(itt_pkg::MODE_POLL, '0, '0, live_id()));
    send_cmd(make_cmd(itt_pkg::MODE_TICK, rand_delta(), '0, '0));
    repeat (8) send_cmd(make_cmd(itt_pkg::MODE_POLL, '0, '0, live_id()));
    send_cmd(make_cmd(itt_pkg::MODE_CREATE, rand_period(), rand_repeat(), '0));
    repeat (20) send_cmd(make_cmd(itt_pkg::MODE_DELETE, '0, '0, live_id()));
    wait_results_drained();
  endtask

  task automatic test_random_mix(int n_items);
    int pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        send_cmd(make_cmd(itt_pkg::MODE_CREATE, rand_period(), rand_repeat(),
                          24'($urandom)));
      end else if (pick < 53) begin
        send_cmd(make_cmd(itt_pkg::MODE_POLL, rand_wide(), 16'($urandom), live_id()));
      end else if (pick < 63) begin
        send_cmd(make_cmd(itt_pkg::MODE_DELETE, rand_wide(), 16'($urandom), live_id()));
      end else if (pick < 83) begin
        send_cmd(make_cmd(itt_pkg::MODE_TICK, rand_delta(), 16'($urandom),
                          24'($urandom)));
      end else begin
        // noise: any mode with every field random
        send_cmd(make_cmd(itt_pkg::mode_t'($urandom_range(0, 3)), rand_wide(),
                          16'($urandom), 24'($urandom)));
      end
      if (i == n_items / 2) wait_results_drained();
    end
  endtask

  // result beats: random back-pressure, each beat checked against the oldest prediction
  initial begin : result_checker
    itt_pkg::res_t exp_r;
    int            stall;
    res_ready = 1'b0;
    sink_idle_en = 1'b1;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 31) == 0) sink_idle_en = !sink_idle_en;
      stall = sink_idle_en ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (res_valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $error("result beat with no command pending: %p", res);
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (res.assigned_id !== exp_r.assigned_id) begin
          $error("assigned_id: expected %0h, actual %0h", exp_r.assigned_id, res.assigned_id);
          n_errors++;
        end
        if (res.fired !== exp_r.fired) begin
          $error("fired: expected %0b, actual %0b", exp_r.fired, res.fired);
          n_errors++;
        end
        if (res.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, res.status);
          n_errors++;
        end
        if (exp_r.fired) n_fired++;
        if (exp_r.status == itt_pkg::STATUS_FULL) n_full++;
        if (exp_r.status == itt_pkg::STATUS_NOT_FOUND) n_not_found++;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    cmd_valid    = 1'b0;
    cmd          = '0;
    src_idle_en  = 1'b1;
    n_errors     = 0;
    n_cmds       = 0;
    n_ticks      = 0;
    n_fired      = 0;
    n_full       = 0;
    n_not_found  = 0;
    for (int s = 0; s < SLOTS; s++) clear_slot(s);
    id_next = 24'd1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_table_full();
    test_random_mix(520);

    wait_results_drained();
    repeat (SLOTS + 8) @(posedge clk);
    $display("covered %0d commands with %0d ticks: %0d polls fired,", n_cmds, n_ticks,
             n_fired);
    $display("%0d creates on a full table, %0d unknown ids, %0d mismatches", n_full,
             n_not_found, n_errors);
    if (n_errors == 0) begin
      $display("tb_interval_timer_table_core: PASS");
    end else begin
      $display("tb_interval_timer_table_core: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("tb_interval_timer_table_core: FAIL");
    $finish;
  end

endmodule
